// ===== hdl/stp_pkg.sv =====
`timescale 1ns / 1ps

package stp_pkg;

    // request codes
    localparam logic [1:0] REQ_VOLUME = 2'd0;
    localparam logic [1:0] REQ_FREQ   = 2'd1;
    localparam logic [1:0] REQ_SAMPLE = 2'd2;
    localparam logic [1:0] REQ_RSVD   = 2'd3;   // unused code, taken and dropped

    // field widths
    localparam int REQ_W    = 2;
    localparam int LEVEL_W  = 8;
    localparam int FREQ_W   = 16;
    localparam int RATE_W   = 16;
    localparam int SAMPLE_W = 6;

    // phase accumulator: remainder (< 2^16) plus twice the frequency (< 2^17)
    localparam int ACC_W  = 18;
    localparam int STEP_W = FREQ_W + 1;

    localparam int PATTERN_DEPTH_DEF = 1024;

endpackage

// ===== hdl/square_tone_pattern_player.sv =====
`timescale 1ns / 1ps

// Square tone pattern player. Three request kinds share one input channel:
// set volume (amplitude = level/4, no busy state), set frequency (rebuilds
// the back bank of a two-bank pattern RAM) and sample (returns one 6-bit
// word). A sample request reads the synchronous RAM when it is taken; the
// load step then moves the word into the output register once it is free.
// A new request is taken while the previous sample still waits on the
// output side. A set-frequency request steps through the pattern entries in
// turn, and at each entry where the phase accumulator wraps it runs an
// 18-step restoring remainder unit (one bit a cycle), then a step for the
// toggle, loop-point compare and write. A set-frequency request with a zero
// sample rate is dropped, as is the unused request code. The pattern RAM
// has no clearing pass: only words from banks that a build filled completely
// ever reach the output.
module square_tone_pattern_player #(
    parameter int PATTERN_DEPTH = stp_pkg::PATTERN_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [stp_pkg::REQ_W-1:0]     i_req_type,
    input  logic [stp_pkg::LEVEL_W-1:0]   i_level,
    input  logic [stp_pkg::FREQ_W-1:0]    i_tone_freq,
    input  logic [stp_pkg::RATE_W-1:0]    i_sample_rate,
    // sample channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [stp_pkg::SAMPLE_W-1:0]  o_sample
);

    localparam int LW   = $clog2(PATTERN_DEPTH + 1);   // lengths and play index
    localparam int PW   = $clog2(PATTERN_DEPTH);       // position inside a bank
    localparam int AW   = $clog2(2 * PATTERN_DEPTH);   // RAM address
    localparam int ACCW = stp_pkg::ACC_W;
    localparam int CW   = $clog2(ACCW);
    localparam int SW   = stp_pkg::SAMPLE_W;
    localparam int RW   = stp_pkg::RATE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_BUILD,
        S_DIV,
        S_WRAP
    } t_state;

    t_state              r_state;

    // player state
    logic                r_front;
    logic [LW-1:0]       r_play_idx;
    logic [LW-1:0]       r_play_len;
    logic [LW-1:0]       r_pend_len;
    logic                r_pend;
    logic [SW-1:0]       r_amp;
    logic [RW-1:0]       r_carry;

    // build datapath
    logic [RW-1:0]            r_rate;
    logic [stp_pkg::STEP_W-1:0] r_step;
    logic [ACCW-1:0]          r_acc;
    logic [RW-1:0]            r_rem;
    logic [CW-1:0]            r_dcnt;
    logic [SW-1:0]            r_lvl;
    logic [RW-1:0]            r_best;
    logic [LW-1:0]            r_bpos;
    logic [PW-1:0]            r_pos;

    // output side
    logic                r_zero;
    logic                r_o_valid;
    logic [SW-1:0]       r_sample;

    // pattern RAM
    logic [SW-1:0]       mem [2 * PATTERN_DEPTH];
    logic [SW-1:0]       r_rd;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [SW-1:0]       mem_wd;
    logic                mem_re;
    logic [AW-1:0]       mem_ra;

    logic                in_acc;
    logic                out_acc;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_o_valid && !i_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_o_valid;
    assign o_sample = r_sample;

    // bank/position to RAM address
    function automatic logic [AW-1:0] f_addr(input logic bank, input logic [PW-1:0] pos);
        logic [AW-1:0] base;
        base = bank ? AW'(PATTERN_DEPTH) : '0;
        return base + AW'(pos);
    endfunction

    // sample request: next play state
    logic          s_taken;
    logic [LW-1:0] s_idx1;
    logic          s_end;
    logic          s_swap;
    logic          s_front;
    logic [LW-1:0] s_len;
    logic [LW-1:0] s_pend_len;
    logic [LW-1:0] s_idx;
    logic          s_zero;

    always_comb begin
        s_taken    = (r_play_idx < r_play_len);
        s_idx1     = s_taken ? r_play_idx + LW'(1) : r_play_idx;
        s_end      = !s_taken || (s_idx1 >= r_play_len);
        s_swap     = s_end && r_pend;
        s_front    = r_front ^ s_swap;
        s_len      = s_swap ? r_pend_len : r_play_len;
        s_pend_len = s_swap ? r_play_len : r_pend_len;
        s_zero     = !s_taken && (s_len == '0);
        if (!s_end || (s_len == '0)) begin
            s_idx = s_idx1;
        end else begin
            s_idx = s_taken ? LW'(0) : LW'(1);
        end
    end

    // build datapath: remainder step, toggle, loop-point search
    logic [RW:0]     d_trial;
    logic            b_wrap;
    logic [SW-1:0]   w_lvl;
    logic            w_hit;
    logic [RW-1:0]   n_best;
    logic [LW-1:0]   n_bpos;
    logic            b_last;

    always_comb begin
        d_trial = {r_rem, r_acc[ACCW-1]};
        b_wrap  = (r_acc >= ACCW'(r_rate));
        w_lvl   = r_amp - r_lvl;
        w_hit   = (r_state == S_WRAP) && (w_lvl == r_amp) && (r_rem < r_best);
        n_best  = w_hit ? r_rem : r_best;
        n_bpos  = w_hit ? LW'(r_pos) : r_bpos;
        b_last  = (r_pos == PW'(PATTERN_DEPTH - 1));
    end

    // RAM port control
    always_comb begin
        mem_we = ((r_state == S_BUILD) && !b_wrap) || (r_state == S_WRAP);
        mem_wa = f_addr(!r_front, r_pos);
        mem_wd = (r_state == S_WRAP) ? w_lvl : r_lvl;
        mem_re = in_acc && (i_req_type == stp_pkg::REQ_SAMPLE);
        mem_ra = s_taken ? f_addr(r_front, r_play_idx[PW-1:0]) : f_addr(s_front, '0);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= mem[mem_ra];
        end
    end

    // control and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_front    <= 1'b0;
            r_play_idx <= '0;
            r_play_len <= '0;
            r_pend_len <= '0;
            r_pend     <= 1'b0;
            r_amp      <= '0;
            r_carry    <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            // output word drains unless the load step refills it this cycle
            if (out_acc && (r_state != S_LOAD)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_req_type)
                            stp_pkg::REQ_VOLUME: begin
                                r_amp <= i_level[stp_pkg::LEVEL_W-1:2];
                            end
                            stp_pkg::REQ_FREQ: begin
                                if (i_sample_rate != '0) begin
                                    r_rate  <= i_sample_rate;
                                    r_step  <= {i_tone_freq, 1'b0};
                                    r_acc   <= ACCW'(r_carry);
                                    r_lvl   <= r_amp;
                                    r_best  <= i_sample_rate;
                                    r_bpos  <= LW'(PATTERN_DEPTH);
                                    r_pos   <= '0;
                                    r_state <= S_BUILD;
                                end
                            end
                            stp_pkg::REQ_SAMPLE: begin
                                r_front    <= s_front;
                                r_play_len <= s_len;
                                r_pend_len <= s_pend_len;
                                r_pend     <= r_pend && !s_swap;
                                r_play_idx <= s_idx;
                                r_zero     <= s_zero;
                                r_state    <= S_LOAD;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_LOAD: begin
                    // read word is in r_rd; wait for a free output register
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid <= 1'b1;
                        r_sample  <= r_zero ? '0 : r_rd;
                        r_state   <= S_IDLE;
                    end
                end
                S_BUILD: begin
                    if (b_wrap) begin
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_acc <= r_acc + ACCW'(r_step);
                        if (b_last) begin
                            r_pend     <= 1'b1;
                            r_pend_len <= n_bpos;
                            r_carry    <= n_best;
                            r_state    <= S_IDLE;
                        end else begin
                            r_pos <= r_pos + PW'(1);
                        end
                    end
                end
                S_DIV: begin
                    // restoring remainder, one dividend bit a cycle
                    if (d_trial >= {1'b0, r_rate}) begin
                        r_rem <= RW'(d_trial - {1'b0, r_rate});
                    end else begin
                        r_rem <= d_trial[RW-1:0];
                    end
                    r_acc  <= {r_acc[ACCW-2:0], 1'b0};
                    r_dcnt <= r_dcnt + CW'(1);
                    if (r_dcnt == CW'(ACCW - 1)) begin
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    r_lvl  <= w_lvl;
                    r_best <= n_best;
                    r_bpos <= n_bpos;
                    r_acc  <= ACCW'(r_rem) + ACCW'(r_step);
                    if (b_last) begin
                        r_pend     <= 1'b1;
                        r_pend_len <= n_bpos;
                        r_carry    <= n_best;
                        r_state    <= S_IDLE;
                    end else begin
                        r_pos   <= r_pos + PW'(1);
                        r_state <= S_BUILD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // play index never runs past a nonzero loop length
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_play_len == '0) || (r_play_idx <= r_play_len))
        else $error("play index beyond loop length");

    // lengths never exceed one bank
    a_len_in_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_play_len <= LW'(PATTERN_DEPTH)) && (r_pend_len <= LW'(PATTERN_DEPTH)))
        else $error("pattern length beyond bank depth");

    // partial remainder stays below the sample rate
    a_rem_below_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) || (r_state == S_WRAP)) |-> (r_rem < r_rate))
        else $error("remainder not reduced");

    // a sample request always goes to the output load step
    a_sample_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_req_type == stp_pkg::REQ_SAMPLE)) |=> (r_state == S_LOAD))
        else $error("sample request lost");

    // the last pattern write leaves a pending pattern
    a_build_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && b_last) |=> (r_pend && (r_state == S_IDLE)))
        else $error("finished build not flagged");

endmodule

// ===== verif/square_tone_pattern_player_tb.sv =====
`timescale 1ns / 1ps

module square_tone_pattern_player_tb;

    localparam int REQ_W       = stp_pkg::REQ_W;
    localparam int LEVEL_W     = stp_pkg::LEVEL_W;
    localparam int FREQ_W      = stp_pkg::FREQ_W;
    localparam int RATE_W      = stp_pkg::RATE_W;
    localparam int SAMPLE_W    = stp_pkg::SAMPLE_W;
    localparam int DEPTH       = stp_pkg::PATTERN_DEPTH_DEF;
    localparam int FREQ_CAP    = 40;   // bound on random pattern builds
    localparam int PRESS_HOLD  = 300;  // long receiver hold-off, in cycles
    localparam int DRAIN_WAIT  = 40;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [REQ_W-1:0]     i_req_type;
    logic [LEVEL_W-1:0]   i_level;
    logic [FREQ_W-1:0]    i_tone_freq;
    logic [RATE_W-1:0]    i_sample_rate;
    logic                 o_valid;
    logic                 i_stall;
    logic [SAMPLE_W-1:0]  o_sample;

    square_tone_pattern_player #(
        .PATTERN_DEPTH(DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_level      (i_level),
        .i_tone_freq  (i_tone_freq),
        .i_sample_rate(i_sample_rate),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample     (o_sample)
    );

    // predicted block state
    logic [SAMPLE_W-1:0] wave_ram [0:2*DEPTH-1];
    logic                ram_front;
    logic [15:0]         rd_pos;
    logic [15:0]         loop_len;
    logic [15:0]         next_len;
    logic                next_ready;
    logic [SAMPLE_W-1:0] vol;
    logic [16:0]         phase_carry;

    logic [SAMPLE_W-1:0] pending_samples [$];
    int                  mismatch_count;
    bit                  tx_idle_en;
    bit                  rx_idle_en;
    int                  stall_hold_req;
    int                  freq_builds;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #50_000_000;
        $display("square_tone_pattern_player_tb: done, errors");
        $finish;
    end

    // fill the back bank with a square wave, pick the loop point
    function automatic void build_wave(input logic [15:0] freq, input logic [15:0] rate);
        logic [17:0]         inc;
        logic [17:0]         acc;
        logic [SAMPLE_W-1:0] lvl;
        logic [16:0]         best;
        int                  best_pos;
        int                  back;
        int                  i;
        inc      = {1'b0, freq, 1'b0};
        acc      = {1'b0, phase_carry};
        lvl      = vol;
        best     = {1'b0, rate};
        best_pos = DEPTH;
        back     = ram_front ? 0 : DEPTH;
        for (i = 0; i < DEPTH; i++) begin
            if (acc >= {2'b00, rate}) begin
                acc = acc % {2'b00, rate};
                lvl = vol - lvl;
                // rising edge with the smallest remainder sets the loop point
                if (lvl == vol && acc < {1'b0, best}) begin
                    best     = acc[16:0];
                    best_pos = i;
                end
            end
            wave_ram[back + i] = lvl;
            acc = acc + inc;
        end
        next_len    = best_pos[15:0];
        phase_carry = best;
        next_ready  = 1'b1;
    endfunction

    // next word of the playing pattern, with bank swap at the end
    function automatic logic [SAMPLE_W-1:0] next_wave_sample();
        logic                taken;
        logic [SAMPLE_W-1:0] s;
        logic [15:0]         t;
        taken = 1'b0;
        s     = '0;
        if (rd_pos < loop_len) begin
            s      = (rd_pos < DEPTH) ? wave_ram[int'(ram_front) * DEPTH + int'(rd_pos)] : '0;
            rd_pos = rd_pos + 16'd1;
            taken  = 1'b1;
            if (rd_pos < loop_len)
                return s;
        end
        if (next_ready) begin
            t          = loop_len;
            ram_front  = ~ram_front;
            loop_len   = next_len;
            next_len   = t;
            next_ready = 1'b0;
        end
        if (loop_len == 16'd0)
            return taken ? s : '0;
        rd_pos = 16'd0;
        if (!taken) begin
            s      = wave_ram[int'(ram_front) * DEPTH];
            rd_pos = 16'd1;
        end
        return s;
    endfunction

    function automatic void apply_request(input logic [REQ_W-1:0] req,
                                          input logic [LEVEL_W-1:0] level,
                                          input logic [FREQ_W-1:0] freq,
                                          input logic [RATE_W-1:0] rate);
        case (req)
            stp_pkg::REQ_VOLUME: begin
                vol = level[7:2];
            end
            stp_pkg::REQ_FREQ: begin
                if (rate != '0)
                    build_wave(freq, rate);
            end
            stp_pkg::REQ_SAMPLE: begin
                pending_samples.push_back(next_wave_sample());
            end
            default: begin
            end
        endcase
    endfunction

    // offer one word, wait for it to be taken, then predict
    task automatic send_word(input logic [REQ_W-1:0] req,
                             input logic [LEVEL_W-1:0] level,
                             input logic [FREQ_W-1:0] freq,
                             input logic [RATE_W-1:0] rate);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_level       <= level;
        i_tone_freq   <= freq;
        i_sample_rate <= rate;
        do
            @(posedge i_clk);
        while (o_stall);
        apply_request(req, level, freq, rate);
    endtask

    // sample request with random don't-care fields
    task automatic send_sample();
        send_word(stp_pkg::REQ_SAMPLE, LEVEL_W'($urandom), FREQ_W'($urandom),
                  RATE_W'($urandom));
    endtask

    // receiver stalls: random bursts, or one long hold-off on request
    initial begin
        int n;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_hold_req > 0) begin
                n = stall_hold_req;
                stall_hold_req = 0;
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // compare each taken sample word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_samples.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected sample word, expected none, actual %0d",
                         $realtime, o_sample);
            end else begin
                logic [SAMPLE_W-1:0] want;
                want = pending_samples.pop_front();
                if (o_sample !== want) begin
                    mismatch_count++;
                    $display("%0t: sample mismatch, expected %0d, actual %0d",
                             $realtime, want, o_sample);
                end
            end
        end
    end

    // playback before any pattern exists, and the ignored requests
    task automatic test_empty_and_ignored();
        send_sample();
        send_sample();
        send_word(stp_pkg::REQ_RSVD, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_word(stp_pkg::REQ_FREQ, 8'hFF, 16'd440, 16'd0);
        send_sample();
    endtask

    // volume and frequency extremes, zero amplitude, short loops
    task automatic test_build_extremes();
        send_word(stp_pkg::REQ_VOLUME, 8'd255, 16'd0, 16'd0);
        send_word(stp_pkg::REQ_FREQ, 8'd0, 16'd0, 16'd65535);       // never wraps
        send_sample();
        send_word(stp_pkg::REQ_VOLUME, 8'd3, 16'hFFFF, 16'hFFFF);   // amplitude 0
        send_word(stp_pkg::REQ_FREQ, 8'd0, 16'd1000, 16'd8000);
        send_sample();
        send_word(stp_pkg::REQ_VOLUME, 8'd255, 16'd0, 16'd0);
        send_word(stp_pkg::REQ_FREQ, 8'd0, 16'd65535, 16'd1);       // wraps every entry
        send_word(stp_pkg::REQ_FREQ, 8'd0, 16'd65535, 16'd65535);
        send_sample();
        send_word(stp_pkg::REQ_VOLUME, 8'd128, 16'd0, 16'd0);
        send_word(stp_pkg::REQ_FREQ, 8'd0, 16'd3000, 16'd12000);
        repeat (8) send_sample();
    endtask

    // mostly sample words, with occasional volume changes, rebuilds and ignored requests
    task automatic test_random_mix(input int count);
        int          done;
        int          r;
        int          rate;
        int          per;
        logic [15:0] freq;
        done = 0;
        while (done < count) begin
            r = $urandom_range(0, 99);
            if (r < 3 && freq_builds < FREQ_CAP) begin
                freq_builds++;
                if ($urandom_range(0, 5) == 0) begin
                    send_word(stp_pkg::REQ_FREQ, LEVEL_W'($urandom), FREQ_W'($urandom),
                              RATE_W'($urandom_range(1, 65535)));
                end else begin
                    // wrap period of roughly 2 to 120 entries keeps builds short
                    rate = $urandom_range(2000, 65535);
                    per  = $urandom_range(2, 120);
                    freq = 16'(rate / (2 * per));
                    send_word(stp_pkg::REQ_FREQ, LEVEL_W'($urandom), freq, 16'(rate));
                end
                done++;
            end else if (r >= 3 && r < 11) begin
                send_word(stp_pkg::REQ_VOLUME, LEVEL_W'($urandom), FREQ_W'($urandom),
                          RATE_W'($urandom));
                done++;
            end else if (r == 11) begin
                send_word(stp_pkg::REQ_RSVD, LEVEL_W'($urandom), FREQ_W'($urandom),
                          RATE_W'($urandom));
            end else if (r == 12) begin
                send_word(stp_pkg::REQ_FREQ, LEVEL_W'($urandom), FREQ_W'($urandom), '0);
            end else begin
                send_sample();
                done++;
            end
        end
    endtask

    // receiver holds off while the sender keeps offering sample words
    task automatic test_backpressure();
        tx_idle_en     = 1'b0;
        rx_idle_en     = 1'b0;
        stall_hold_req = PRESS_HOLD;
        repeat (60) send_sample();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // closing stretch at full rate on both sides
    task automatic test_full_rate_tail();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_mix(100);
        repeat (10) send_sample();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_req_type    <= '0;
        i_level       <= '0;
        i_tone_freq   <= '0;
        i_sample_rate <= '0;
        for (int k = 0; k < 2 * DEPTH; k++)
            wave_ram[k] = '0;
        ram_front      = 1'b0;
        rd_pos         = '0;
        loop_len       = '0;
        next_len       = '0;
        next_ready     = 1'b0;
        vol            = '0;
        phase_carry    = '0;
        mismatch_count = 0;
        freq_builds    = 0;
        stall_hold_req = 0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_ignored();
        test_build_extremes();
        test_random_mix(1000);
        test_backpressure();
        test_full_rate_tail();
        i_valid <= 1'b0;

        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("square_tone_pattern_player_tb: done, clean");
        else
            $display("square_tone_pattern_player_tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/stp_pkg.sv
hdl/square_tone_pattern_player.sv
verif/square_tone_pattern_player_tb.sv
